/* design/bbfa_pkg.sv */
// Shared types, codes and constants of the bitmap best-fit allocator.
package bbfa_pkg;

	localparam int unsigned DataMax  = 4096;
	localparam int unsigned RowBits  = 16;
	localparam int unsigned RowCount = DataMax / RowBits;
	localparam int unsigned RowW     = $clog2(RowCount);
	localparam int unsigned StepBits = 8;
	localparam int unsigned SizeW    = 13;
	localparam int unsigned AddrW    = 16;
	localparam int unsigned HalfW    = RowW + 1;

	localparam logic [SizeW-1:0] DATA_MAX_C = SizeW'(DataMax);

	typedef enum logic [0:0] {
		OP_RESERVE = 1'b0,
		OP_RELEASE = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_ZERO_SIZE = 2'd1,
		ST_NO_FIT    = 2'd2,
		ST_UNMANAGED = 2'd3
	} status_t;

	typedef enum logic [0:0] {
		CFG_DATA_BASE = 1'b0,
		CFG_DATA_SIZE = 1'b1
	} cfg_idx_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_FIN,
		S_DECIDE,
		S_CHECK,
		S_FILL,
		S_DRAIN,
		S_RESP
	} fsm_t;

	typedef struct packed {
		logic             operation;
		logic [AddrW-1:0] seg_address;
		logic [SizeW-1:0] seg_size;
	} in_t;

	typedef struct packed {
		logic [1:0]       status;
		logic [AddrW-1:0] block_address;
	} out_t;

	// Best run found so far by the scanner
	typedef struct packed {
		logic             found;
		logic [SizeW-1:0] idx;
		logic [SizeW-1:0] len;
	} best_t;

endpackage

/* design/bbfa_map_ram.sv */
// Busy map memory: 16-bit rows, registered read, per-row valid bits for reset.
module bbfa_map_ram
	import bbfa_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               rd_en,
	input  logic [RowW-1:0]    rd_addr,
	output logic [RowBits-1:0] rd_data,
	input  logic               wr_en,
	input  logic [RowW-1:0]    wr_addr,
	input  logic [RowBits-1:0] wr_data
);

	logic [RowBits-1:0] mem [RowCount];
	logic [RowCount-1:0] vld_q;
	logic [RowBits-1:0] rd_q;
	logic               rd_vld_q;

	// storage array
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	// row valid bits; an unwritten row reads as all free
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (wr_en) begin
				vld_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_vld_q <= vld_q[rd_addr];
			end
		end
	end

	assign rd_data = rd_vld_q ? rd_q : '0;

endmodule

/* design/bbfa_scan.sv */
// Free-run tracker: walks eight map bits per step and keeps the best fit.
module bbfa_scan
	import bbfa_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                clear,
	input  logic                step,
	input  logic [StepBits-1:0] bits,
	input  logic [SizeW-1:0]    i0,
	input  logic [SizeW-1:0]    lim,
	input  logic [SizeW-1:0]    size,
	output best_t               best
);

	logic [SizeW-1:0] rs_q;
	logic [SizeW-1:0] delta_q;
	best_t            best_q;

	logic [SizeW-1:0] rs_n;
	logic [SizeW-1:0] delta_n;
	best_t            best_n;

	// run boundaries within this step, in index order
	always_comb begin
		logic [SizeW-1:0] pos;
		logic [SizeW-1:0] len;
		logic             fin;
		rs_n    = rs_q;
		delta_n = delta_q;
		best_n  = best_q;
		for (int j = 0; j < StepBits; j++) begin
			pos = i0 + SizeW'(j);
			fin = (pos < lim && bits[j]) || pos == lim;
			len = pos - rs_n;
			if (fin) begin
				if (len >= size && (!best_n.found || (len - size) < delta_n)) begin
					best_n.found = 1'b1;
					best_n.idx   = rs_n;
					best_n.len   = len;
					delta_n      = len - size;
				end
				rs_n = pos + 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rs_q    <= '0;
			delta_q <= '0;
			best_q  <= '0;
		end else if (clear) begin
			rs_q    <= '0;
			delta_q <= '0;
			best_q  <= '0;
		end else if (step) begin
			rs_q    <= rs_n;
			delta_q <= delta_n;
			best_q  <= best_n;
		end
	end

	assign best = best_q;

endmodule

/* design/bitmap_best_fit_allocator_top.sv */
// Bitmap best-fit allocator top level: control sequencer, config and result register.
// One word in, one word out. A reserve scans the whole 4096-bit busy map, eight bits
// per cycle from a 256 x 16 memory, and on a fit marks the block in each 16-bit row
// it touches; a release checks its window and clears the rows it covers if managed;
// a zero-size request goes straight to the response. The next word is accepted
// while a result still waits on the output. Reset needs no clearing pass.
module bitmap_best_fit_allocator_top
	import bbfa_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  in_t        in_data,
	output logic       out_valid,
	input  logic       out_ready,
	output out_t       out_data,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic       cfg_index,
	input  logic [15:0] cfg_data
);

	fsm_t             state_q, state_n;
	in_t              in_q;
	logic [HalfW-1:0] h_q;
	logic [RowW-1:0]  r_q, last_row_q;
	logic [SizeW-1:0] lo_q, hi_q;
	logic             set_q;
	logic [SizeW-1:0] last_size_q;
	logic [AddrW-1:0] base_q;
	logic [SizeW-1:0] dsize_q;
	out_t             res_q, out_q;
	logic             out_valid_q;
	logic             wr_s1;
	logic [RowW-1:0]  row_s1;

	logic               rd_en;
	logic [RowW-1:0]    rd_addr;
	logic [RowBits-1:0] rd_data, wr_data, mask;
	logic               scan_step;
	logic [StepBits-1:0] scan_bits;
	logic [SizeW-1:0]   scan_i0, lim;
	best_t              best;

	logic [SizeW-1:0]   pick_idx, pick_hi, pick_last;
	logic [AddrW:0]     rel_end, win_end;
	logic               rel_ok;
	logic [SizeW-1:0]   rel_lo, rel_last;
	logic               res_load;

	assign lim = (dsize_q > DATA_MAX_C) ? DATA_MAX_C : dsize_q;

	// placement of the reserved block inside the chosen run
	always_comb begin
		pick_idx = best.idx;
		if (in_q.seg_size < last_size_q) begin
			pick_idx = best.idx + (best.len - in_q.seg_size);
		end
		pick_hi   = pick_idx + in_q.seg_size;
		pick_last = pick_hi - 1'b1;
	end

	// release window check on exact sums
	assign rel_end  = {1'b0, in_q.seg_address} + (AddrW+1)'(in_q.seg_size);
	assign win_end  = {1'b0, base_q} + (AddrW+1)'(lim);
	assign rel_ok   = in_q.seg_address >= base_q && rel_end <= win_end;
	assign rel_lo   = SizeW'(in_q.seg_address - base_q);
	assign rel_last = rel_lo + in_q.seg_size - 1'b1;

	// next state
	always_comb begin
		state_n = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					if (in_data.seg_size == '0) state_n = S_RESP;
					else if (in_data.operation == OP_RELEASE) state_n = S_CHECK;
					else state_n = S_SCAN;
				end
			end
			S_SCAN:   if (h_q == '1) state_n = S_FIN;
			S_FIN:    state_n = S_DECIDE;
			S_DECIDE: state_n = best.found ? S_FILL : S_RESP;
			S_CHECK:  state_n = rel_ok ? S_FILL : S_RESP;
			S_FILL:   if (r_q == last_row_q) state_n = S_DRAIN;
			S_DRAIN:  state_n = S_RESP;
			S_RESP:   if (!out_valid_q || out_ready) state_n = S_IDLE;
			default:  state_n = S_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		in_ready  = 1'b0;
		cfg_ready = 1'b0;
		rd_en     = 1'b0;
		rd_addr   = '0;
		scan_step = 1'b0;
		scan_bits = '0;
		scan_i0   = '0;
		res_load  = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready  = 1'b1;
				cfg_ready = 1'b1;
				rd_en     = in_valid;
			end
			S_SCAN: begin
				rd_en     = h_q[0];
				rd_addr   = h_q[HalfW-1:1] + 1'b1;
				scan_step = 1'b1;
				scan_bits = h_q[0] ? rd_data[RowBits-1:StepBits] : rd_data[StepBits-1:0];
				scan_i0   = {1'b0, h_q, 3'b000};
			end
			S_FIN: begin
				scan_step = 1'b1;
				scan_i0   = DATA_MAX_C;
			end
			S_FILL: begin
				rd_en   = 1'b1;
				rd_addr = r_q;
			end
			S_RESP:  res_load = !out_valid_q || out_ready;
			default: ;
		endcase
	end

	// row mask for the read-modify-write of the busy map
	always_comb begin
		logic [SizeW-1:0] p;
		for (int j = 0; j < RowBits; j++) begin
			p       = {1'b0, row_s1, 4'(j)};
			mask[j] = p >= lo_q && p < hi_q;
		end
		wr_data = set_q ? (rd_data | mask) : (rd_data & ~mask);
	end

	// control and datapath registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			h_q         <= '0;
			r_q         <= '0;
			last_row_q  <= '0;
			last_size_q <= '0;
			base_q      <= '0;
			dsize_q     <= '0;
			out_valid_q <= 1'b0;
			wr_s1       <= 1'b0;
			row_s1      <= '0;
			set_q       <= 1'b0;
		end else begin
			state_q <= state_n;
			wr_s1   <= 1'b0;
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == CFG_DATA_BASE) base_q <= cfg_data;
				else dsize_q <= cfg_data[SizeW-1:0];
			end
			if (out_valid_q && out_ready) out_valid_q <= 1'b0;
			if (res_load) out_valid_q <= 1'b1;
			case (state_q)
				S_IDLE:   h_q <= '0;
				S_SCAN:   h_q <= h_q + 1'b1;
				S_DECIDE: begin
					if (best.found) begin
						last_size_q <= in_q.seg_size;
						r_q         <= pick_idx[11:4];
						last_row_q  <= pick_last[11:4];
						set_q       <= 1'b1;
					end
				end
				S_CHECK: begin
					last_size_q <= in_q.seg_size;
					r_q         <= rel_lo[11:4];
					last_row_q  <= rel_last[11:4];
					set_q       <= 1'b0;
				end
				S_FILL: begin
					wr_s1  <= 1'b1;
					row_s1 <= r_q;
					r_q    <= r_q + 1'b1;
				end
				default: ;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			in_q <= in_data;
			res_q <= '{status: ST_ZERO_SIZE, block_address: '0};
		end
		if (res_load) out_q <= res_q;
		case (state_q)
			S_DECIDE: begin
				lo_q <= pick_idx;
				hi_q <= pick_hi;
				if (best.found)
					res_q <= '{status: ST_OK, block_address: base_q + AddrW'(pick_idx)};
				else
					res_q <= '{status: ST_NO_FIT, block_address: '0};
			end
			S_CHECK: begin
				lo_q  <= rel_lo;
				hi_q  <= rel_lo + in_q.seg_size;
				res_q <= '{status: rel_ok ? ST_OK : ST_UNMANAGED, block_address: '0};
			end
			default: ;
		endcase
	end

	bbfa_map_ram u_ram (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data),
		.wr_en   (wr_s1),
		.wr_addr (row_s1),
		.wr_data (wr_data)
	);

	bbfa_scan u_scan (
		.clk    (clk),
		.arst_n (arst_n),
		.clear  (in_valid && in_ready),
		.step   (scan_step),
		.bits   (scan_bits),
		.i0     (scan_i0),
		.lim    (lim),
		.size   (in_q.seg_size),
		.best   (best)
	);

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// map writes only follow a fill read in the cycle before
	a_wr_after_fill: assert property (@(posedge clk) disable iff (!arst_n)
		wr_s1 |-> $past(state_q == S_FILL))
		else $error("map write without fill read");

	// a failed scan always answers no-fit
	a_nofit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DECIDE && !best.found) |=> res_q.status == ST_NO_FIT)
		else $error("failed reserve not reported");

	// an accepted word leaves idle
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> state_q != S_IDLE)
		else $error("accepted word dropped");

endmodule
